### rtl/heart_rate_measurement_parser_defines.svh
// ---------------------------------------------------------------------------
// heart rate measurement parser assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef HEART_RATE_MEASUREMENT_PARSER_DEFINES_SVH
`define HEART_RATE_MEASUREMENT_PARSER_DEFINES_SVH

// same-cycle implication
`define HRM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrm assertion failed");

// next-cycle implication
`define HRM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrm assertion failed");

`endif

### rtl/hrm_pkg.sv
// ---------------------------------------------------------------------------
// hrm_pkg
// flag codes, conversion constants and the byte decode struct
// ---------------------------------------------------------------------------
package hrm_pkg;

  localparam logic [7:0] FLAG_RATE16  = 8'h01;
  localparam logic [7:0] FLAG_CONTACT = 8'h06;
  localparam logic [7:0] FLAG_ENERGY  = 8'h08;
  localparam logic [7:0] FLAG_RR      = 8'h10;

  localparam logic [9:0]  RR_SCALE = 10'd1000;
  localparam logic [25:0] RR_ROUND = 26'd512;
  localparam int          RR_SHIFT = 10;

  localparam logic [7:0] POS_MAX = 8'd255;

  // what one packet byte does to the working state
  typedef struct packed {
    logic       first;     // flags byte, clears the working state
    logic       rate_lo;   // low (or only) rate byte
    logic       rate_hi;   // high byte of a 16-bit rate
    logic       rr_lo;     // low byte of an rr pair
    logic       rr_hi;     // high byte of an rr pair
    logic [6:0] rr_idx;    // rr pair index within the packet
    logic       len_ok;    // packet long enough if this byte is the last
  } dec_t;

  // raw rr in 1/1024 s to ms, rounded
  function automatic logic [15:0] rr_to_ms(input logic [15:0] raw);
    logic [25:0] prod;
    prod = {10'd0, raw} * {16'd0, RR_SCALE} + RR_ROUND;
    return prod[RR_SHIFT +: 16];
  endfunction

endpackage

### rtl/hrm_dec.sv
// ---------------------------------------------------------------------------
// hrm_dec
// classifies one packet byte by its position and the packet flags
// ---------------------------------------------------------------------------
module hrm_dec (
  input  logic [7:0]    pos,
  input  logic [7:0]    flags,
  input  logic [7:0]    data,
  output hrm_pkg::dec_t dec
);
  import hrm_pkg::*;

  logic [7:0] flags_eff;
  logic [7:0] rr_start;
  logic [7:0] rr_off;
  logic [8:0] len;
  logic       rate16;
  logic       energy;
  logic       in_rr;

  always_comb begin
    flags_eff = (pos == 8'd0) ? data : flags;
    rate16    = |(flags_eff & FLAG_RATE16);
    energy    = |(flags_eff & FLAG_ENERGY);
    rr_start  = 8'd2 + {7'd0, rate16} + {6'd0, energy, 1'b0};
    rr_off    = pos - rr_start;
    len       = {1'b0, pos} + 9'd1;

    in_rr = (pos != 8'd0) && (pos != 8'd1) && !((pos == 8'd2) && rate16) &&
            (|(flags_eff & FLAG_RR)) && (pos >= rr_start);

    dec.first   = (pos == 8'd0);
    dec.rate_lo = (pos == 8'd1);
    dec.rate_hi = (pos == 8'd2) && rate16;
    dec.rr_lo   = in_rr && !rr_off[0];
    dec.rr_hi   = in_rr && rr_off[0];
    dec.rr_idx  = rr_off[7:1];
    dec.len_ok  = (len >= 9'd2) && !(rate16 && (len < 9'd3)) &&
                  !(energy && (len < {1'b0, rr_start}));
  end

endmodule

### rtl/heart_rate_measurement_parser.sv
// ---------------------------------------------------------------------------
// heart_rate_measurement_parser
// byte-serial parser for heart rate measurement packets
// ---------------------------------------------------------------------------
// Takes one packet byte per cycle, flags byte first, with tlast on the final
// byte. Each accepted byte lands in an input register; while it sits there, one
// pass of decode logic (position/flags classification plus a single 16x10
// multiply for the rr conversion) updates the working state as the byte
// advances, and on a last byte the parse result is written to the output
// register. Throughput is one byte per clock; the input keeps flowing while
// a result waits to be taken. Only a last byte needs the output register,
// so input stalls only when a new result meets an unconsumed one. A packet
// that is too short bumps the error count and repeats the previously stored
// values.
// ---------------------------------------------------------------------------
module heart_rate_measurement_parser #(
  parameter int MAX_RR = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // data_byte[7:0], timestamp_ms[39:8]
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata   // packet_ok[0], heart_rate_bpm[16:1],
                                   // skin_contact[17], packet_flags[25:18],
                                   // rr_valid_cnt[28:26], rr_interval_0[44:29],
                                   // rr_interval_1[60:45], rr_interval_2[76:61],
                                   // rr_interval_3[92:77], sample_sequence[124:93],
                                   // error_total[156:125], sample_time_ms[188:157],
                                   // zero pad[191:189]
);
  import hrm_pkg::*;

  localparam int CW   = $clog2(MAX_RR + 1);
  localparam int NREP = (MAX_RR < 4) ? MAX_RR : 4;

  // input register
  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  logic [31:0] in_ts_r;
  logic        adv;

  // working state for the packet in flight
  logic [7:0]    pos_r, pos_nxt;
  logic [7:0]    flags_r, flags_nxt;
  logic [15:0]   rate_r, rate_nxt;
  logic [7:0]    hold_r, hold_nxt;
  logic [CW-1:0] wcnt_r, wcnt_nxt;
  logic [15:0]   wvals_r [MAX_RR];
  logic [15:0]   wvals_nxt [MAX_RR];

  // values of the last good packet
  logic [15:0]   st_rate_r, st_rate_nxt;
  logic          st_contact_r, st_contact_nxt;
  logic [7:0]    st_flags_r, st_flags_nxt;
  logic [CW-1:0] st_cnt_r, st_cnt_nxt;
  logic [15:0]   st_vals_r [MAX_RR];
  logic [15:0]   st_vals_nxt [MAX_RR];
  logic [31:0]   st_time_r, st_time_nxt;
  logic [31:0]   good_r, good_nxt;
  logic [31:0]   bad_r, bad_nxt;

  // output register
  logic          out_v_r;
  logic [191:0]  out_data_r, out_data_nxt;

  dec_t          dec;
  logic [15:0]   rr_ms;
  logic          ok;
  logic [2:0]    rep_cnt;
  logic [15:0]   rep_vals [4];

  // byte advances unless it is a last byte meeting a held result
  assign adv        = in_v_r && (!in_last_r || !out_v_r || out_tready);
  assign in_tready  = !in_v_r || adv;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  hrm_dec u_dec (
    .pos   (pos_r),
    .flags (flags_r),
    .data  (in_byte_r),
    .dec   (dec)
  );

  assign rr_ms = rr_to_ms({in_byte_r, hold_r});
  assign ok    = dec.len_ok;

  always_comb begin
    pos_nxt   = pos_r;
    flags_nxt = flags_r;
    rate_nxt  = rate_r;
    hold_nxt  = hold_r;
    wcnt_nxt  = wcnt_r;
    for (int i = 0; i < MAX_RR; i++) begin
      wvals_nxt[i] = wvals_r[i];
    end

    st_rate_nxt    = st_rate_r;
    st_contact_nxt = st_contact_r;
    st_flags_nxt   = st_flags_r;
    st_cnt_nxt     = st_cnt_r;
    for (int i = 0; i < MAX_RR; i++) begin
      st_vals_nxt[i] = st_vals_r[i];
    end
    st_time_nxt = st_time_r;
    good_nxt    = good_r;
    bad_nxt     = bad_r;

    // per-byte field capture
    if (dec.first) begin
      flags_nxt = in_byte_r;
      rate_nxt  = '0;
      hold_nxt  = '0;
      wcnt_nxt  = '0;
      for (int i = 0; i < MAX_RR; i++) begin
        wvals_nxt[i] = '0;
      end
    end else if (dec.rate_lo) begin
      rate_nxt = {8'd0, in_byte_r};
    end else if (dec.rate_hi) begin
      rate_nxt = {in_byte_r, rate_r[7:0]};
    end else if (dec.rr_lo && (int'(dec.rr_idx) < MAX_RR)) begin
      hold_nxt = in_byte_r;
    end else if (dec.rr_hi) begin
      // pairs past MAX_RR match no slot and are dropped
      for (int i = 0; i < MAX_RR; i++) begin
        if (int'(dec.rr_idx) == i) begin
          wvals_nxt[i] = rr_ms;
          wcnt_nxt     = CW'(i + 1);
        end
      end
    end

    // end of packet: commit or count the error
    if (in_last_r) begin
      pos_nxt = '0;
      if (ok) begin
        st_rate_nxt    = rate_nxt;
        st_contact_nxt = ((flags_nxt & FLAG_CONTACT) == FLAG_CONTACT);
        st_flags_nxt   = flags_nxt;
        st_cnt_nxt     = wcnt_nxt;
        for (int i = 0; i < MAX_RR; i++) begin
          st_vals_nxt[i] = wvals_nxt[i];
        end
        st_time_nxt = in_ts_r;
        good_nxt    = good_r + 32'd1;
      end else begin
        bad_nxt = bad_r + 32'd1;
      end
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + 8'd1;
    end

    // reported view: four rr slots, count capped at seven
    rep_cnt = (int'(st_cnt_nxt) > 7) ? 3'd7 : 3'(st_cnt_nxt);
    for (int i = 0; i < 4; i++) begin
      rep_vals[i] = '0;
    end
    for (int i = 0; i < NREP; i++) begin
      rep_vals[i] = st_vals_nxt[i];
    end

    out_data_nxt = {3'd0, st_time_nxt, bad_nxt, good_nxt,
                    rep_vals[3], rep_vals[2], rep_vals[1], rep_vals[0],
                    rep_cnt, st_flags_nxt, st_contact_nxt, st_rate_nxt, ok};
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata[7:0];
      in_last_r <= in_tlast;
      in_ts_r   <= in_tdata[39:8];
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      flags_r      <= '0;
      rate_r       <= '0;
      hold_r       <= '0;
      wcnt_r       <= '0;
      st_rate_r    <= '0;
      st_contact_r <= 1'b0;
      st_flags_r   <= '0;
      st_cnt_r     <= '0;
      st_time_r    <= '0;
      good_r       <= '0;
      bad_r        <= '0;
      for (int i = 0; i < MAX_RR; i++) begin
        wvals_r[i]   <= '0;
        st_vals_r[i] <= '0;
      end
    end else if (adv) begin
      pos_r        <= pos_nxt;
      flags_r      <= flags_nxt;
      rate_r       <= rate_nxt;
      hold_r       <= hold_nxt;
      wcnt_r       <= wcnt_nxt;
      st_rate_r    <= st_rate_nxt;
      st_contact_r <= st_contact_nxt;
      st_flags_r   <= st_flags_nxt;
      st_cnt_r     <= st_cnt_nxt;
      st_time_r    <= st_time_nxt;
      good_r       <= good_nxt;
      bad_r        <= bad_nxt;
      for (int i = 0; i < MAX_RR; i++) begin
        wvals_r[i]   <= wvals_nxt[i];
        st_vals_r[i] <= st_vals_nxt[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last_r) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

### rtl/hrm_chk.sv
// ---------------------------------------------------------------------------
// hrm_chk
// port-level checks on result ordering, counters and stored values
// ---------------------------------------------------------------------------
`include "heart_rate_measurement_parser_defines.svh"

module hrm_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [191:0] out_tdata
);

  logic         out_acc;
  logic         pkt_ok;
  logic [31:0]  seq;
  logic [31:0]  err;
  logic [162:0] kept;
  logic [31:0]  seq_r;
  logic [31:0]  err_r;
  logic [162:0] kept_r;
  logic         cnt_good;

  assign out_acc = out_tvalid && out_tready;
  assign pkt_ok  = out_tdata[0];
  assign seq     = out_tdata[124:93];
  assign err     = out_tdata[156:125];
  // stored fields, excluding the ok bit and both counters
  assign kept    = {out_tdata[191:157], out_tdata[92:1], 36'd0};

  // each result moves exactly one of the two counters by one
  assign cnt_good = pkt_ok ? ((seq == seq_r + 32'd1) && (err == err_r))
                           : ((err == err_r + 32'd1) && (seq == seq_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= '0;
      err_r  <= '0;
      kept_r <= '0;
    end else if (out_acc) begin
      seq_r  <= seq;
      err_r  <= err;
      kept_r <= kept;
    end
  end

  `HRM_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `HRM_ASSERT_IMP(a_counters, out_acc, cnt_good)
  `HRM_ASSERT_IMP(a_reject_keeps, out_acc && !pkt_ok, kept == kept_r)
  `HRM_ASSERT_IMP(a_contact, out_acc && pkt_ok, out_tdata[17] == (out_tdata[20] && out_tdata[19]))
  `HRM_ASSERT_NXT(a_in_not_stuck, in_tvalid && !in_tready, out_tvalid)

endmodule

bind heart_rate_measurement_parser hrm_chk u_hrm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
